// ===== rtl/stack_queue_rotate_engine_defines.svh =====
// ----------------------------------------------------------------------------
// Stack/queue rotate engine: assertion macros
// Shared assertion wrappers, clocked on clk_i and quiet while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef STACK_QUEUE_ROTATE_ENGINE_DEFINES_SVH
`define STACK_QUEUE_ROTATE_ENGINE_DEFINES_SVH

// Property sampled on the rising clock edge, disabled during reset.
`define SQRE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form: the consequent is checked in the same cycle as the antecedent.
`define SQRE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sqre_pkg.sv =====
// ----------------------------------------------------------------------------
// Stack/queue rotate engine package
// Sizes, codes and ring index helpers shared by the engine and its memory.
// ----------------------------------------------------------------------------
package sqre_pkg;

  localparam int DEPTH = 64;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int DATA_W = 32;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [DATA_W-1:0] word_t;

  typedef enum logic [2:0] {
    ACT_PUSH = 3'd0,
    ACT_POP  = 3'd1,
    ACT_SWAP = 3'd2,
    ACT_ROTL = 3'd3,
    ACT_ROTR = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_POP_EMPTY  = 2'd1,
    ST_SWAP_SHORT = 2'd2,
    ST_PUSH_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_WR_B,
    S_DONE
  } state_e;

  // Ring index of the entry that lies off places below p. While off is at most
  // DEPTH, one conditional subtraction brings the sum back into range.
  function automatic ptr_t ring_add(ptr_t p, cnt_t off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(p) + SUM_W'(off);
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  function automatic ptr_t ring_back(ptr_t p);
    ptr_t r;
    if (p == '0) begin
      r = PTR_W'(DEPTH - 1);
    end else begin
      r = p - ptr_t'(1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/sqre_ring_mem.sv =====
// ----------------------------------------------------------------------------
// Ring memory
// One write port and one read port; read data appears the cycle after the
// address is presented.
// ----------------------------------------------------------------------------
module sqre_ring_mem (
  input  logic           clk_i,
  input  logic           we_i,
  input  sqre_pkg::ptr_t waddr_i,
  input  sqre_pkg::word_t wdata_i,
  input  sqre_pkg::ptr_t raddr_i,
  output sqre_pkg::word_t rdata_o
);
  import sqre_pkg::*;

  word_t mem_q [DEPTH];
  word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/stack_queue_rotate_engine.sv =====
// ----------------------------------------------------------------------------
// Stack/queue rotate engine
// A bounded store of signed 32-bit values in a ring memory, used as a stack
// or a queue, with push, pop, swap and both rotations.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload (lowest bits first)
// s_axis    in         action[2:0], push_value[34:3], zero pad to 40 bits
// m_axis    out        status[1:0], top_value[33:2], entry_count[40:34], pad to 48
// cfg       in         cfg_wdata_i = queue_mode, written when cfg_we_i is high
//
// Push, unknown actions, failed requests, a pop that empties the store and a
// rotation of fewer than two values skip to S_DONE; other pops and rotations
// pass S_READ, and a swap S_READ and S_WR_B, as the ring memory has one read
// and one write port. The result is registered as the sequencer leaves S_DONE,
// and the input is ready again from that edge. Reset empties the store at once;
// the memory is not cleared. A stalled result holds the sequencer in S_DONE.
// ----------------------------------------------------------------------------
`include "stack_queue_rotate_engine_defines.svh"

module stack_queue_rotate_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,   // queue_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // action[2:0], push_value[34:3]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // status[1:0], top_value[33:2], entry_count[40:34]
);
  import sqre_pkg::*;

  state_e state_q, state_d;
  logic   queue_mode_q;
  logic [2:0] act_q, act_d;
  word_t  val_q, val_d;
  word_t  top_q, top_d;
  ptr_t   ptr_q, ptr_d;
  cnt_t   count_q, count_d;
  status_e status_q, status_d;

  logic        m_valid_q, m_valid_d;
  logic [47:0] m_data_q, m_data_d;

  logic  mem_we;
  ptr_t  mem_waddr;
  word_t mem_wdata;
  ptr_t  mem_raddr;
  word_t mem_rdata;

  logic        in_fire;
  logic        out_free;
  logic        two_held;
  logic [31:0] cnt_wide;
  word_t       top_out;

  assign in_fire  = s_axis_tvalid & s_axis_tready;
  assign out_free = ~m_valid_q | m_axis_tready;
  assign two_held = count_q >= cnt_t'(2);
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  sqre_ring_mem u_ring_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_DONE;
        case (act_q)
          ACT_POP: begin
            if (count_q > cnt_t'(1)) begin
              state_d = S_READ;
            end
          end
          ACT_SWAP, ACT_ROTL, ACT_ROTR: begin
            if (two_held) begin
              state_d = S_READ;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_READ: begin
        state_d = (act_q == ACT_SWAP) ? S_WR_B : S_DONE;
      end
      S_WR_B: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    act_d     = act_q;
    val_d     = val_q;
    top_d     = top_q;
    ptr_d     = ptr_q;
    count_d   = count_q;
    status_d  = status_q;
    mem_we    = 1'b0;
    mem_waddr = ptr_q;
    mem_wdata = val_q;
    mem_raddr = ring_add(ptr_q, cnt_t'(1));
    cnt_wide  = 32'(count_q);
    top_out   = (count_q == '0) ? '0 : top_q;
    m_valid_d = m_valid_q & ~m_axis_tready;
    m_data_d  = m_data_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          act_d    = s_axis_tdata[2:0];
          val_d    = s_axis_tdata[34:3];
          status_d = ST_OK;
        end
      end
      S_EXEC: begin
        case (act_q)
          ACT_PUSH: begin
            if (count_q >= cnt_t'(DEPTH)) begin
              status_d = ST_PUSH_FULL;
            end else if (queue_mode_q) begin
              mem_we    = 1'b1;
              mem_waddr = ring_add(ptr_q, count_q);
              count_d   = count_q + cnt_t'(1);
              if (count_q == '0) begin
                top_d = val_q;
              end
            end else begin
              mem_we    = 1'b1;
              mem_waddr = ring_back(ptr_q);
              ptr_d     = ring_back(ptr_q);
              count_d   = count_q + cnt_t'(1);
              top_d     = val_q;
            end
          end
          ACT_POP: begin
            if (count_q == '0) begin
              status_d = ST_POP_EMPTY;
            end else begin
              ptr_d   = ring_add(ptr_q, cnt_t'(1));
              count_d = count_q - cnt_t'(1);
            end
          end
          ACT_SWAP: begin
            if (!two_held) begin
              status_d = ST_SWAP_SHORT;
            end
          end
          ACT_ROTL: begin
            // The old top is copied below the bottom while the next entry is read.
            if (two_held) begin
              mem_we    = 1'b1;
              mem_waddr = ring_add(ptr_q, count_q);
              mem_wdata = top_q;
              ptr_d     = ring_add(ptr_q, cnt_t'(1));
            end
          end
          ACT_ROTR: begin
            mem_raddr = ring_add(ptr_q, count_q - cnt_t'(1));
          end
          default: ;
        endcase
      end
      S_READ: begin
        case (act_q)
          ACT_SWAP: begin
            // The second entry moves up; the old top waits in val_q.
            mem_we    = 1'b1;
            mem_waddr = ptr_q;
            mem_wdata = mem_rdata;
            val_d     = top_q;
            top_d     = mem_rdata;
          end
          ACT_ROTR: begin
            mem_we    = 1'b1;
            mem_waddr = ring_back(ptr_q);
            mem_wdata = mem_rdata;
            ptr_d     = ring_back(ptr_q);
            top_d     = mem_rdata;
          end
          default: top_d = mem_rdata;
        endcase
      end
      S_WR_B: begin
        mem_we    = 1'b1;
        mem_waddr = ring_add(ptr_q, cnt_t'(1));
        mem_wdata = val_q;
      end
      S_DONE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {7'd0, cnt_wide[6:0], top_out, status_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      queue_mode_q <= 1'b0;
      ptr_q        <= '0;
      count_q      <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        queue_mode_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    val_q    <= val_d;
    top_q    <= top_d;
    status_q <= status_d;
    m_data_q <= m_data_d;
  end

  `SQRE_ASSERT(a_count_bound, count_q <= cnt_t'(DEPTH), "entry count exceeds depth")
  `SQRE_ASSERT_IMP(a_count_in_exec, count_q != $past(count_q), $past(state_q) == S_EXEC,
                   "entry count changed outside the execute step")
  `SQRE_ASSERT_IMP(a_result_from_done, $rose(m_axis_tvalid), $past(state_q) == S_DONE,
                   "result presented without a finished request")

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stack/queue rotate engine testbench
// Drives push, pop, swap, rotation and unused action requests in stack and
// queue mode. A behavioural ring store predicts the status, top value and
// count for each request, and every result is checked in order. Both stream
// sides idle at random, and the receiver holds off long enough to stall the
// input.
// ----------------------------------------------------------------------------
module testbench;
  import sqre_pkg::*;

  localparam logic [2:0] ACT_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] ACT_LAST_UNUSED  = 3'd7;

  typedef struct packed {
    status_e          status;
    word_t            top_value;
    logic [6:0]       entry_count;
  } store_view_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // action[2:0], push_value[34:3]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // status[1:0], top_value[33:2], entry_count[40:34]

  // Behavioural copy of the store, updated as each request is accepted.
  word_t ring_mem [DEPTH];
  int    top_slot;
  int    held_count;
  bit    queue_mode;

  store_view_t awaited_views [$];
  int          mismatch_count;
  bit          sender_idle;
  bit          receiver_idle;
  int          hold_off_cycles;

  stack_queue_rotate_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic int ring_slot(int off);
    return (top_slot + off) % DEPTH;
  endfunction

  function automatic int slot_above(int slot);
    return (slot + DEPTH - 1) % DEPTH;
  endfunction

  function automatic store_view_t apply_action(logic [2:0] act, word_t val);
    store_view_t view;
    word_t       moved;
    view.status = ST_OK;
    case (act)
      ACT_PUSH: begin
        if (held_count >= DEPTH) begin
          view.status = ST_PUSH_FULL;
        end else if (queue_mode) begin
          ring_mem[ring_slot(held_count)] = val;
          held_count++;
        end else begin
          top_slot = slot_above(top_slot);
          ring_mem[top_slot] = val;
          held_count++;
        end
      end
      ACT_POP: begin
        if (held_count == 0) begin
          view.status = ST_POP_EMPTY;
        end else begin
          top_slot = ring_slot(1);
          held_count--;
        end
      end
      ACT_SWAP: begin
        if (held_count < 2) begin
          view.status = ST_SWAP_SHORT;
        end else begin
          moved = ring_mem[ring_slot(0)];
          ring_mem[ring_slot(0)] = ring_mem[ring_slot(1)];
          ring_mem[ring_slot(1)] = moved;
        end
      end
      ACT_ROTL: begin
        // With a full store the slot below the bottom is the top itself.
        if (held_count >= 2) begin
          moved = ring_mem[ring_slot(0)];
          ring_mem[ring_slot(held_count)] = moved;
          top_slot = ring_slot(1);
        end
      end
      ACT_ROTR: begin
        if (held_count >= 2) begin
          moved = ring_mem[ring_slot(held_count - 1)];
          top_slot = slot_above(top_slot);
          ring_mem[top_slot] = moved;
        end
      end
      default: begin
      end
    endcase
    view.top_value   = (held_count == 0) ? '0 : ring_mem[top_slot];
    view.entry_count = 7'(held_count);
    return view;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic word_t pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Called just after a falling edge; returns just after a falling edge.
  task automatic send_request(logic [2:0] act, word_t val);
    int gap;
    gap = sender_idle ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {5'b0, val, act};
    do @(posedge clk_i); while (!s_axis_tready);
    awaited_views.push_back(apply_action(act, val));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (awaited_views.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_queue_mode(bit mode);
    wait_drained();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = mode;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    queue_mode  = mode;
  endtask

  task automatic check_result(logic [47:0] data);
    store_view_t want;
    if (awaited_views.size() == 0) begin
      $display("%0t: unexpected result, expected none, got %h", $time, data);
      mismatch_count++;
    end else begin
      want = awaited_views.pop_front();
      if (data[1:0] !== want.status) begin
        $display("%0t: status mismatch, expected %0d, got %0d",
                 $time, want.status, data[1:0]);
        mismatch_count++;
      end
      if (data[33:2] !== want.top_value) begin
        $display("%0t: top value mismatch, expected %h, got %h",
                 $time, want.top_value, data[33:2]);
        mismatch_count++;
      end
      if (data[40:34] !== want.entry_count) begin
        $display("%0t: count mismatch, expected %0d, got %0d",
                 $time, want.entry_count, data[40:34]);
        mismatch_count++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      check_result(m_axis_tdata);
    end
  end

  // Result side: random stalls, plus long hold-offs requested by a test.
  initial begin : receiver
    int stall;
    int gap;
    stall = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles > 0) begin
        stall = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        stall--;
      end else if (receiver_idle) begin
        gap = pick_gap();
        m_axis_tready = (gap == 0);
        stall = (gap > 0) ? gap - 1 : 0;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  task automatic test_directed();
    logic [2:0] act;
    set_queue_mode(1'b0);
    // Every action but push on an empty store.
    send_request(ACT_POP, 32'h0);
    send_request(ACT_SWAP, 32'h0);
    send_request(ACT_ROTL, 32'h0);
    send_request(ACT_ROTR, 32'h0);
    send_request(ACT_FIRST_UNUSED, 32'hffff_ffff);
    // A single value: swap fails, the rotations leave it alone.
    send_request(ACT_PUSH, 32'h7fff_ffff);
    send_request(ACT_SWAP, 32'h0);
    send_request(ACT_ROTL, 32'h0);
    send_request(ACT_ROTR, 32'h0);
    send_request(ACT_PUSH, 32'h8000_0000);
    send_request(ACT_PUSH, 32'h0000_0000);
    send_request(ACT_PUSH, 32'hffff_ffff);
    send_request(ACT_SWAP, 32'h0);
    send_request(ACT_ROTL, 32'h0);
    send_request(ACT_ROTR, 32'h0);
    for (act = ACT_FIRST_UNUSED; act != ACT_LAST_UNUSED; act++) begin
      send_request(act, 32'ha5a5_a5a5);
    end
    send_request(ACT_LAST_UNUSED, 32'h5a5a_5a5a);
    repeat (5) send_request(ACT_POP, 32'h0);
    set_queue_mode(1'b1);
    send_request(ACT_PUSH, 32'h1234_5678);
    send_request(ACT_PUSH, 32'hfedc_ba98);
    send_request(ACT_SWAP, 32'h0);
    send_request(ACT_POP, 32'h0);
    send_request(ACT_POP, 32'h0);
  endtask

  // Bursts with a random push bias, so the count wanders between empty and
  // full.
  task automatic run_random(int count);
    int sent;
    int burst;
    int push_pct;
    logic [2:0] act;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(10, 60);
      case ($urandom_range(0, 3))
        0:       push_pct = 10;
        1:       push_pct = 40;
        2:       push_pct = 60;
        default: push_pct = 90;
      endcase
      repeat (burst) begin
        if ($urandom_range(0, 99) < 2) begin
          act = 3'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_UNUSED));
        end else if ($urandom_range(0, 99) < push_pct) begin
          act = ACT_PUSH;
        end else begin
          case ($urandom_range(0, 4))
            0, 1:    act = ACT_POP;
            2:       act = ACT_SWAP;
            3:       act = ACT_ROTL;
            default: act = ACT_ROTR;
          endcase
        end
        send_request(act, pick_value());
        sent++;
      end
    end
  endtask

  task automatic test_random_stack();
    set_queue_mode(1'b0);
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    run_random(450);
  endtask

  task automatic test_random_queue();
    set_queue_mode(1'b1);
    run_random(450);
  endtask

  task automatic test_fill_and_drain(bit mode);
    set_queue_mode(mode);
    while (held_count < DEPTH) send_request(ACT_PUSH, pick_value());
    repeat (3) send_request(ACT_PUSH, pick_value());
    send_request(ACT_ROTL, 32'h0);
    send_request(ACT_ROTR, 32'h0);
    send_request(ACT_SWAP, 32'h0);
    send_request(ACT_ROTL, 32'h0);
    while (held_count > 0) send_request(ACT_POP, 32'h0);
    repeat (2) send_request(ACT_POP, 32'h0);
  endtask

  // The receiver holds off while requests keep coming, so the engine fills
  // and stops accepting; afterwards the sender waits for everything to drain.
  task automatic test_backpressure();
    sender_idle     = 1'b0;
    receiver_idle   = 1'b0;
    hold_off_cycles = 300;
    run_random(60);
    wait_drained();
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
  endtask

  task automatic test_mode_flips();
    int i;
    for (i = 0; i < 8; i++) begin
      set_queue_mode(i[0] ? 1'b0 : 1'b1);
      sender_idle   = (i % 3 != 2);
      receiver_idle = (i % 3 != 2);
      run_random(60);
    end
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    top_slot        = 0;
    held_count      = 0;
    queue_mode      = 1'b0;
    mismatch_count  = 0;
    sender_idle     = 1'b1;
    receiver_idle   = 1'b1;
    hold_off_cycles = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random_stack();
    test_fill_and_drain(1'b0);
    test_random_queue();
    test_fill_and_drain(1'b1);
    test_backpressure();
    test_mode_flips();
    wait_drained();

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
